// ===== sv/rrm_pkg.sv =====
package rrm_pkg;

  localparam int unsigned SumW  = 16;
  localparam int unsigned NumW  = SumW + 1;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned StepW = $clog2(DivSteps + 1);

  localparam logic [SumW-1:0] CountLimit = 16'hFFFE;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_HOLD = 2'd2
  } state_e;

  typedef struct packed {
    logic            valid;
    logic [1:0]      kind;
    logic [SumW-1:0] sample;
  } acc_req_t;

endpackage

// ===== sv/rrm_acc.sv =====
module rrm_acc
  import rrm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  acc_req_t        req_i,
  output logic [SumW-1:0] sum_o,
  output logic [SumW-1:0] count_o
);

  logic [SumW-1:0] sum_q, sum_d;
  logic [SumW-1:0] count_q, count_d;
  logic [NumW-1:0] wide_sum;
  logic [NumW-1:0] count_inc;
  logic            rescale;

  assign wide_sum  = {1'b0, sum_q} + {1'b0, req_i.sample};
  assign count_inc = {1'b0, count_q} + NumW'(1);
  assign rescale   = wide_sum[NumW-1] || (count_q >= CountLimit);

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (req_i.valid) begin
      case (req_i.kind)
        KIND_ADD: begin
          if (rescale) begin
            if (count_q[0]) begin
              // odd history: halve the combined sum and round the count up
              sum_d   = wide_sum[NumW-1:1];
              count_d = count_inc[NumW-1:1];
            end else begin
              sum_d   = {1'b0, sum_q[SumW-1:1]} + req_i.sample;
              count_d = {1'b0, count_q[SumW-1:1]} + SumW'(1);
            end
          end else begin
            sum_d   = wide_sum[SumW-1:0];
            count_d = count_inc[SumW-1:0];
          end
        end
        KIND_CLEAR: begin
          sum_d   = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = count_q;

endmodule

// ===== sv/rrm_div.sv =====
module rrm_div
  import rrm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [SumW-1:0] den_i,
  output logic            done_o,
  output logic [SumW-1:0] quo_o
);

  logic [NumW-1:0]  num_q, num_d;
  logic [SumW-1:0]  rem_q, rem_d;
  logic [SumW-1:0]  den_q;
  logic [StepW-1:0] step_q, step_d;
  logic             done_q, done_d;
  logic [NumW-1:0]  shifted;
  logic [NumW:0]    diff;
  logic             fits;

  // one quotient bit per cycle: shift the numerator into the remainder
  assign shifted = {rem_q, num_q[NumW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign fits    = !diff[NumW];

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      step_d = StepW'(DivSteps);
    end else if (step_q != '0) begin
      num_d  = {num_q[NumW-2:0], fits};
      rem_d  = fits ? diff[SumW-1:0] : shifted[SumW-1:0];
      step_d = step_q - StepW'(1);
      done_d = (step_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q[SumW-1:0];

endmodule

// ===== sv/rescaling_running_mean.sv =====
// Adds and clears update the registered sum and count on acceptance; a read
// gives its result after 17 divider steps, the hold state and the output
// register, or later while it is still occupied. Adds and clears go one per
// cycle while idle; a read holds off new requests until its result is loaded.
// The bit-serial restoring divider retires one quotient bit per cycle.
// Reset (rst_ni low, asynchronous): sum and count clear to zero, no result.
module rescaling_running_mean
  import rrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] mean
  output logic [0:0]  m_axis_tuser_o    // [0] empty_res
);

  state_e          state_q, state_d;
  acc_req_t        acc_req;
  logic            in_fire;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] count;
  logic            div_start;
  logic            div_done;
  logic [SumW-1:0] quo;
  logic [NumW-1:0] numer;
  logic            empty_q, empty_d;
  logic            out_valid_q, out_valid_d;
  logic [SumW-1:0] out_mean_q, out_mean_d;
  logic            out_empty_q, out_empty_d;
  logic            out_free;
  logic            out_load;

  // Take a request only while no read is in flight; the output register
  // decouples the two sides so adds keep flowing while a result waits.
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign acc_req.valid  = in_fire;
  assign acc_req.kind   = s_axis_tuser_i;
  assign acc_req.sample = s_axis_tdata_i;

  rrm_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (acc_req),
    .sum_o   (sum),
    .count_o (count)
  );

  // rounding bias: add half the count before dividing
  assign numer     = {1'b0, sum} + {2'b00, count[SumW-1:1]};
  assign div_start = in_fire && (s_axis_tuser_i == KIND_READ);

  rrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (numer),
    .den_i   (count),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d  = state_q;
    empty_d  = empty_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          // remember an empty accumulator; the divider result is then ignored
          empty_d = (count == '0);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // hold the quotient until the output register can take it
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_mean_d  = out_mean_q;
    out_empty_d = out_empty_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_mean_d  = empty_q ? '0 : quo;
      out_empty_d = empty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    empty_q     <= empty_d;
    out_mean_q  <= out_mean_d;
    out_empty_q <= out_empty_d;
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_mean_q;
  assign m_axis_tuser_o[0] = out_empty_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rrm_pkg::*;

  // Kind code 3 is not part of the package enum; the block must drop it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned DrainCycles = 40;   // read latency plus margin
  localparam int unsigned RandPerLeg  = 230;  // requests per idling leg
  localparam int unsigned NumRows     = 24;
  // The slowest correct run has every request a read, stalled by the sparse
  // idling legs.
  localparam int unsigned LimitCycles = 600_000;

  typedef struct packed {
    logic [15:0] mean;
    logic        is_empty;
  } mean_res_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    int unsigned reps;
    bit          typed;      // use the typed-in result below
    logic [15:0] mean;
    logic        is_empty;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;  // [15:0] sample
  logic [1:0]  s_axis_tuser_i = '0;  // [1:0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;       // [15:0] mean
  logic [0:0]  m_axis_tuser_o;       // [0] empty_res

  // Shadow accumulator and the means still owed by the block.
  logic [15:0] acc_sum = '0;
  logic [15:0] acc_count = '0;
  mean_res_t   pending_means[$];

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 86;
  int unsigned mismatch_count = 0;
  int unsigned n_adds = 0, n_reads = 0, n_clears = 0, n_dropped = 0;
  int unsigned n_rescales = 0, n_means_checked = 0;

  // Directed requests: extremes, every kind, overflow rescale with odd and
  // even counts, wrap of the even-count sum, empty reads.
  stim_row_t directed_rows [NumRows] = '{
    '{KIND_READ,   16'h0000, 1,     1'b1, 16'h0000, 1'b1},  // empty after reset
    '{KIND_ADD,    16'hFFFF, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_READ,   16'h0000, 1,     1'b1, 16'hFFFF, 1'b0},  // one max sample
    '{KIND_ADD,    16'h0001, 1,     1'b0, 16'h0000, 1'b0},  // overflow, odd count
    '{KIND_READ,   16'h0000, 1,     1'b1, 16'h8000, 1'b0},
    '{KIND_ADD,    16'hFFFF, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_ADD,    16'h0000, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_ADD,    16'hFFFF, 1,     1'b0, 16'h0000, 1'b0},  // even count, sum wraps
    '{KIND_READ,   16'h0000, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_CLEAR,  16'hFFFF, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_READ,   16'h0000, 1,     1'b1, 16'h0000, 1'b1},
    '{KIND_UNUSED, 16'hFFFF, 1,     1'b0, 16'h0000, 1'b0},  // must change nothing
    '{KIND_READ,   16'hFFFF, 1,     1'b1, 16'h0000, 1'b1},
    '{KIND_ADD,    16'h0000, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_READ,   16'h0000, 1,     1'b1, 16'h0000, 1'b0},  // zero mean, not empty
    '{KIND_ADD,    16'h0001, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_ADD,    16'h0000, 3,     1'b0, 16'h0000, 1'b0},  // a few zero samples
    '{KIND_READ,   16'h0000, 1,     1'b1, 16'h0000, 1'b0},  // 1/5 rounds down
    '{KIND_ADD,    16'h1234, 1,     1'b0, 16'h0000, 1'b0},  // plain add
    '{KIND_READ,   16'h0000, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_CLEAR,  16'h0000, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_ADD,    16'h0001, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_ADD,    16'h0002, 1,     1'b0, 16'h0000, 1'b0},
    '{KIND_READ,   16'h0000, 1,     1'b1, 16'h0002, 1'b0}   // 3/2 rounds up
  };

  rescaling_running_mean u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Fold one sample into the shadow sum and count; halve the history first
  // when the sum would overflow or the count sits at its limit.
  function automatic void fold_sample(input logic [15:0] smp);
    logic [16:0] wide;
    logic [16:0] cnt_up;
    wide   = {1'b0, acc_sum} + {1'b0, smp};
    cnt_up = {1'b0, acc_count} + 17'd1;
    if (wide[16] || acc_count >= CountLimit) begin
      n_rescales++;
      if (acc_count[0]) begin
        acc_sum   = wide[16:1];
        acc_count = cnt_up[16:1];
      end else begin
        acc_sum   = (acc_sum >> 1) + smp;
        acc_count = (acc_count >> 1) + 16'd1;
      end
    end else begin
      acc_sum   = wide[15:0];
      acc_count = cnt_up[15:0];
    end
  endfunction

  // Advance the shadow state by one accepted request; return 1 when the
  // request owes a mean, and that mean in res.
  function automatic bit predict_request(input logic [1:0] kind, input logic [15:0] smp,
                                         output mean_res_t res);
    int unsigned quot;
    res = '0;
    case (kind)
      KIND_ADD: begin
        n_adds++;
        fold_sample(smp);
        return 1'b0;
      end
      KIND_READ: begin
        n_reads++;
        if (acc_count == '0) begin
          res.is_empty = 1'b1;
        end else begin
          quot     = (int'(acc_sum) + int'(acc_count >> 1)) / int'(acc_count);
          res.mean = quot[15:0];
        end
        return 1'b1;
      end
      KIND_CLEAR: begin
        n_clears++;
        acc_sum   = '0;
        acc_count = '0;
        return 1'b0;
      end
      default: begin
        n_dropped++;
        return 1'b0;
      end
    endcase
  endfunction

  // Present one request and hold it until the block takes it. Leave valid
  // high on return so that back-to-back requests need no second assignment.
  task automatic send_request(input logic [1:0] kind, input logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= smp;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
  endtask

  // Send one request and queue the mean it owes; a typed-in value wins over
  // the predicted one, while the shadow state advances either way.
  task automatic issue_request(input logic [1:0] kind, input logic [15:0] smp,
                               input bit typed, input mean_res_t typed_res);
    mean_res_t predicted;
    send_request(kind, smp);
    if (predict_request(kind, smp, predicted)) begin
      pending_means.push_back(typed ? typed_res : predicted);
    end
  endtask

  // Result side: compare every accepted mean with the oldest one owed, then
  // draw the next ready value.
  always @(posedge clk_i) begin
    mean_res_t got;
    mean_res_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.mean     = m_axis_tdata_o;
      got.is_empty = m_axis_tuser_o[0];
      if (pending_means.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: unexpected result mean=%h empty=%b", $realtime, got.mean,
                   got.is_empty);
        end
      end else begin
        want = pending_means.pop_front();
        n_means_checked++;
        if (got.mean !== want.mean || got.is_empty !== want.is_empty) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result mismatch: mean exp=%h got=%h, empty exp=%b got=%b",
                     $realtime, want.mean, got.mean, want.is_empty, got.is_empty);
          end
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    int unsigned leg;
    int unsigned issued;
    int unsigned pick;
    logic [1:0]  kind;
    logic [15:0] smp;
    mean_res_t   typed_res;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, run under the first idling leg.
    foreach (directed_rows[r]) begin
      typed_res.mean     = directed_rows[r].mean;
      typed_res.is_empty = directed_rows[r].is_empty;
      repeat (directed_rows[r].reps) begin
        issue_request(directed_rows[r].kind, directed_rows[r].sample,
                      directed_rows[r].typed, typed_res);
      end
    end

    // Random requests in three legs: receiver sparse, sender sparse, both busy.
    for (leg = 0; leg < 3; leg++) begin
      case (leg)
        0: begin send_idle_pct = 28; recv_idle_pct = 86; end
        1: begin send_idle_pct = 86; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      issued = 0;
      while (issued < RandPerLeg) begin
        pick = $urandom_range(99);
        if (pick < 58)      kind = KIND_ADD;
        else if (pick < 88) kind = KIND_READ;
        else if (pick < 93) kind = KIND_CLEAR;
        else                kind = KIND_UNUSED;
        // Mix small and near-max samples so that sum overflow rescales happen
        // often on both odd and even counts.
        case ($urandom_range(3))
          0:       smp = 16'($urandom_range(255));
          1:       smp = 16'($urandom_range(16'hFFFF, 16'hF000));
          default: smp = 16'($urandom);
        endcase
        issue_request(kind, smp, 1'b0, '0);
        if (kind != KIND_UNUSED) issued++;
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain: wait for every owed mean, then watch for stray results.
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d adds (%0d with history rescale), %0d reads, %0d clears,",
             n_adds, n_rescales, n_reads, n_clears);
    $display("%0d unused-kind drops; %0d means checked, %0d mismatches.",
             n_dropped, n_means_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * 2 * ClkHalf);
    $display("Timeout with %0d means still owed", pending_means.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rrm_pkg.sv
sv/rrm_acc.sv
sv/rrm_div.sv
sv/rescaling_running_mean.sv
bench/tb_top.sv
